[rtl/quadrature_encoder_decoder_defines.svh]
// Assertion macros used by the quadrature decoder checker.
`ifndef QUADRATURE_ENCODER_DECODER_DEFINES_SVH
`define QUADRATURE_ENCODER_DECODER_DEFINES_SVH

// Implication check on the rising clock edge, off while reset is held.
`define QED_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled signal holds its value until the transaction completes.
`define QED_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

[rtl/qed_pkg.sv]
// Shared types and constants of the quadrature encoder decoder.
package qed_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic [DATA_W-1:0] MOD_ALL_ONES  = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] MOD_RESET     = DATA_W'(10);

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic signed [1:0] DET_NONE = 2'sb00;
    localparam logic signed [1:0] DET_CW   = 2'sb01;
    localparam logic signed [1:0] DET_CCW  = 2'sb11;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_CCW_ST   = 3'd1,
        PH_CCW_RUN  = 3'd2,
        PH_CCW_WAIT = 3'd3,
        PH_CW_ST    = 3'd4,
        PH_CW_RUN   = 3'd5,
        PH_CW_WAIT  = 3'd6
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic signed [1:0]  detent;
    } fsm_result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[rtl/qed_if.sv]
// Valid/ready channel interfaces: samples in, results out, modulus writes.
interface qed_in_if;
    logic                valid;
    logic                ready;
    logic                operation;
    logic                pin_a;
    logic                pin_b;
    logic signed [31:0]  load_value;

    modport source (output valid, operation, pin_a, pin_b, load_value, input ready);
    modport sink   (input valid, operation, pin_a, pin_b, load_value, output ready);
endinterface

interface qed_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  total_steps;
    logic        [31:0]  wrapped_steps;
    logic signed [1:0]   detent_event;
    logic        [2:0]   phase;

    modport source (output valid, total_steps, wrapped_steps, detent_event, phase,
                    input ready);
    modport sink   (input valid, total_steps, wrapped_steps, detent_event, phase,
                    output ready);
endinterface

interface qed_cfg_if;
    logic         valid;
    logic         ready;
    logic [31:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/quadrature_encoder_decoder.sv]
// Top level of the quadrature encoder decoder with detent counting.
//
//  channel  | dir | payload                                            | handshake
//  ---------+-----+----------------------------------------------------+-----------
//  in_ch    | in  | operation, pin_a, pin_b, load_value                | valid/ready
//  out_ch   | out | total_steps, wrapped_steps, detent_event, phase    | valid/ready
//  cfg      | in  | data (modulus)                                     | valid/ready
//
//  Each input transaction goes through these steps from acceptance to its result
//  being offered: the accepting edge updates the phase and count and loads the shared
//  remainder unit, which works one dividend bit a cycle; the sequencer then retires
//  the remainder and loads the output register once it is free. in_ch.ready is high
//  only while the sequencer is idle, so no input is taken while the sequencer holds one.
//  A result waiting in the output register does not block the next input;
//  a new result waits in the sequencer until the output register is free.
//  Reset clears the phase to idle, the count to zero and the modulus to 10;
//  cfg.ready is always high.
module quadrature_encoder_decoder (
    input  logic        clk,
    input  logic        rst_n,
    qed_in_if.sink      in_ch,
    qed_out_if.source   out_ch,
    qed_cfg_if.sink     cfg
);
    import qed_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } seq_state_t;

    seq_state_t          state_reg;
    phase_t              phase_reg;
    logic [DATA_W-1:0]   count_reg;
    logic [DATA_W-1:0]   modulus_reg;
    logic signed [1:0]   detent_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_total_reg;
    logic [DATA_W-1:0]   out_wrapped_reg;
    logic signed [1:0]   out_detent_reg;
    phase_t              out_phase_reg;

    fsm_result_t         fsm_res;
    div_status_t         div_stat;
    logic [DATA_W-1:0]   div_rem;
    logic [DATA_W-1:0]   count_next;
    logic [DATA_W-1:0]   eff_modulus;
    logic                in_accept;
    logic                out_free;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;

    // A zero modulus selects the all-ones divisor.
    assign eff_modulus = (modulus_reg == '0) ? MOD_ALL_ONES : modulus_reg;

    qed_phase_fsm u_fsm (
        .operation (in_ch.operation),
        .a_low     (!in_ch.pin_a),
        .b_low     (!in_ch.pin_b),
        .phase_cur (phase_reg),
        .result    (fsm_res)
    );

    // Load replaces the count; a step adds the sign-extended detent (wraps).
    assign count_next = (in_ch.operation == OP_LOAD)
                      ? DATA_W'(in_ch.load_value)
                      : count_reg + {{(DATA_W-2){fsm_res.detent[1]}}, fsm_res.detent};

    qed_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .dividend  (count_next),
        .divisor   (eff_modulus),
        .status    (div_stat),
        .remainder (div_rem)
    );

    // Sequencer, architectural state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            modulus_reg   <= MOD_RESET;
            detent_reg    <= DET_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                modulus_reg <= cfg.data;
            end
            // Drop the result once the sink takes it, unless a new one replaces it.
            if (out_valid_reg && out_ch.ready && state_reg != S_HOLD)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        count_reg  <= count_next;
                        phase_reg  <= fsm_res.phase;
                        detent_reg <= fsm_res.detent;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    // Hold the finished result until the output register frees up.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload, loaded together with the valid flag.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_HOLD && out_free)
        begin
            out_total_reg   <= count_reg;
            out_wrapped_reg <= div_rem;
            out_detent_reg  <= detent_reg;
            out_phase_reg   <= phase_reg;
        end
    end

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.total_steps   = out_total_reg;
    assign out_ch.wrapped_steps = out_wrapped_reg;
    assign out_ch.detent_event  = out_detent_reg;
    assign out_ch.phase         = out_phase_reg;

endmodule

[rtl/qed_phase_fsm.sv]
// Next-phase and detent decision of the detent tracking machine.
module qed_phase_fsm (
    input  logic                 operation,
    input  logic                 a_low,
    input  logic                 b_low,
    input  qed_pkg::phase_t      phase_cur,
    output qed_pkg::fsm_result_t result
);
    import qed_pkg::*;

    always_comb
    begin
        result.phase  = phase_cur;
        result.detent = DET_NONE;
        if (operation == OP_STEP)
        begin
            case (phase_cur)
                PH_CCW_ST:
                begin
                    if (b_low)       result.phase = PH_CCW_RUN;
                    else if (!a_low) result.phase = PH_IDLE;
                end
                PH_CCW_RUN:
                begin
                    if (!a_low)      result.phase = PH_CCW_WAIT;
                    else if (!b_low) result.phase = PH_CCW_ST;
                end
                PH_CCW_WAIT:
                begin
                    if (!b_low)
                    begin
                        result.phase  = PH_IDLE;
                        result.detent = DET_CCW;
                    end
                    else if (a_low)  result.phase = PH_CCW_RUN;
                end
                PH_CW_ST:
                begin
                    if (a_low)       result.phase = PH_CW_RUN;
                    else if (!b_low) result.phase = PH_IDLE;
                end
                PH_CW_RUN:
                begin
                    if (!b_low)      result.phase = PH_CW_WAIT;
                    else if (!a_low) result.phase = PH_CW_ST;
                end
                PH_CW_WAIT:
                begin
                    if (!a_low)
                    begin
                        result.phase  = PH_IDLE;
                        result.detent = DET_CW;
                    end
                    else if (b_low)  result.phase = PH_CW_RUN;
                end
                default:
                begin
                    // idle, and the unreachable code treated as idle
                    if (a_low)       result.phase = PH_CCW_ST;
                    else if (b_low)  result.phase = PH_CW_ST;
                    else             result.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/qed_divider.sv]
// Radix-2 restoring remainder unit, one dividend bit per cycle.
module qed_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qed_pkg::DATA_W-1:0]    dividend,
    input  logic [qed_pkg::DATA_W-1:0]    divisor,
    output qed_pkg::div_status_t          status,
    output logic [qed_pkg::DATA_W-1:0]    remainder
);
    import qed_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W-1:0]   dvd_reg, dvd_next;
    logic [DATA_W-1:0]   dsr_reg, dsr_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;

    logic [DATA_W:0]     trial;
    logic [DATA_W:0]     diff;
    logic                fits;

    // Shift the next dividend bit into the partial remainder, subtract if it fits.
    assign trial = {rem_reg, dvd_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

[rtl/qed_checker.sv]
// Port-level checks of the quadrature encoder decoder, bound to the top level.
`include "quadrature_encoder_decoder_defines.svh"

module qed_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [31:0]  out_total,
    input  logic [1:0]   out_detent,
    input  logic [2:0]   out_phase
);
    import qed_pkg::*;

    // A finished detent always returns the machine to idle.
    `QED_ASSERT(a_detent_idle, clk, rst_n, (out_valid && out_detent != DET_NONE) |-> (out_phase == PH_IDLE), "detent reported outside idle phase")

    // The detent code never takes the meaningless value.
    `QED_ASSERT(a_detent_code, clk, rst_n, out_valid |-> (out_detent != 2'b10), "invalid detent code")

    // One transaction at a time: input closes right after acceptance.
    `QED_ASSERT(a_in_busy, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "input accepted while busy")

    // A stalled result holds.
    `QED_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_total, "stalled count changed")

endmodule

bind quadrature_encoder_decoder qed_checker u_qed_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_total  (out_ch.total_steps),
    .out_detent (out_ch.detent_event),
    .out_phase  (out_ch.phase)
);

[test/quadrature_encoder_decoder_tb.sv]
// Self-checking testbench for the quadrature encoder decoder: detent tracking, loads and modulus.
module quadrature_encoder_decoder_tb;

    import qed_pkg::*;

    // Run length and guard.
    localparam int ITEM_TARGET  = 1750;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int QUIET_START  = 900;
    localparam int QUIET_LEN    = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int BLOCK_LATENCY = 40;

    // One expected result transaction, typed at the block's widths.
    typedef struct {
        logic signed [31:0] total;
        logic        [31:0] wrapped;
        logic signed [1:0]  detent;
        phase_t             phase;
    } detent_result_t;

    logic clk;
    logic rst_n;

    qed_in_if  in_ch ();
    qed_out_if out_ch ();
    qed_cfg_if cfg ();

    quadrature_encoder_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Shadow of the block's state and modulus register; phase and count advance on every accepted transaction.
    phase_t             phase_shadow;
    logic signed [31:0] count_shadow;
    logic        [31:0] modulus_shadow;

    detent_result_t pending_results[$];

    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  cw_detents;
    int  ccw_detents;
    int  modulus_writes;
    int  cycle_count;
    bit  idle_on;
    int  hold_req;
    logic hold_on;

    // Free-running clock, period 10.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Work out the result of one accepted transaction and queue it.
    function automatic void decode_sample(input logic op, input logic pin_a,
                                          input logic pin_b,
                                          input logic signed [31:0] value);
        detent_result_t res;
        logic a_low;
        logic b_low;
        logic [31:0] divisor;
        logic [31:0] as_unsigned;
        res.detent = DET_NONE;
        a_low = !pin_a;
        b_low = !pin_b;
        if (op == OP_LOAD)
        begin
            // Load replaces the count and leaves the phase alone.
            count_shadow = value;
        end
        else
        begin
            case (phase_shadow)
                PH_CCW_ST:
                    if (b_low) phase_shadow = PH_CCW_RUN;
                    else if (!a_low) phase_shadow = PH_IDLE;
                PH_CCW_RUN:
                    if (!a_low) phase_shadow = PH_CCW_WAIT;
                    else if (!b_low) phase_shadow = PH_CCW_ST;
                PH_CCW_WAIT:
                    if (!b_low)
                    begin
                        phase_shadow = PH_IDLE;
                        count_shadow = count_shadow - 32'sd1;
                        res.detent = DET_CCW;
                    end
                    else if (a_low) phase_shadow = PH_CCW_RUN;
                PH_CW_ST:
                    if (a_low) phase_shadow = PH_CW_RUN;
                    else if (!b_low) phase_shadow = PH_IDLE;
                PH_CW_RUN:
                    if (!b_low) phase_shadow = PH_CW_WAIT;
                    else if (!a_low) phase_shadow = PH_CW_ST;
                PH_CW_WAIT:
                    if (!a_low)
                    begin
                        phase_shadow = PH_IDLE;
                        count_shadow = count_shadow + 32'sd1;
                        res.detent = DET_CW;
                    end
                    else if (b_low) phase_shadow = PH_CW_RUN;
                default:
                    // Idle: A has priority when both pins drop together.
                    if (a_low) phase_shadow = PH_CCW_ST;
                    else if (b_low) phase_shadow = PH_CW_ST;
                    else phase_shadow = PH_IDLE;
            endcase
        end
        divisor = (modulus_shadow == '0) ? MOD_ALL_ONES : modulus_shadow;
        as_unsigned = count_shadow;
        res.total = count_shadow;
        res.wrapped = as_unsigned % divisor;
        res.phase = phase_shadow;
        pending_results.push_back(res);
    endfunction

    // Offer one input transaction, hold it until accepted, then predict its result.
    // Keep valid high between back-to-back transactions; drop it only for a gap.
    task automatic send_item(input logic op, input logic pin_a, input logic pin_b,
                             input logic signed [31:0] value);
        if (idle_on && $urandom_range(99) < 13)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 60);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.pin_a      <= pin_a;
        in_ch.pin_b      <= pin_b;
        in_ch.load_value <= value;
        do @(posedge clk); while (!in_ch.ready);
        decode_sample(op, pin_a, pin_b, value);
        items_sent++;
    endtask

    task automatic step_pins(input logic pin_a, input logic pin_b);
        send_item(OP_STEP, pin_a, pin_b, $urandom);
    endtask

    task automatic load_count(input logic signed [31:0] value);
        send_item(OP_LOAD, 1'($urandom_range(1)), 1'($urandom_range(1)), value);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline go quiet.
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (BLOCK_LATENCY) @(posedge clk);
    endtask

    // Write the modulus register; call only with the block idle.
    task automatic write_modulus(input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        modulus_shadow = value;
        modulus_writes++;
        cfg.valid <= 1'b0;
    endtask

    // Walk the pins through one detent in gray order, with dwell and backtracking.
    // Position 0 and 4 are both pins high; the early pin drops first.
    task automatic walk_detent(input bit clockwise);
        int   pos;
        int   roll;
        logic early;
        logic late;
        pos = 0;
        while (pos < 4)
        begin
            roll = $urandom_range(99);
            if (roll < 12 && pos > 0)
                pos--;
            else if (roll >= 20)
                pos++;
            early = (pos == 1 || pos == 2) ? 1'b0 : 1'b1;
            late  = (pos == 2 || pos == 3) ? 1'b0 : 1'b1;
            if (clockwise)
                step_pins(late, early);
            else
                step_pins(early, late);
        end
    endtask

    // Favor count values near the wrap points so detents cross them.
    function automatic logic signed [31:0] pick_load_value();
        case ($urandom_range(6))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            3: return 32'sd0;
            4: return $signed(32'($urandom_range(40))) - 32'sd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return MOD_ALL_ONES;
            2: return $urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    // Known detent sequences under the reset modulus: wrap both ways, backtracking,
    // a load in the middle of a detent and both pins dropping together from idle.
    task automatic test_directed_detents();
        load_count(32'sh7FFF_FFFF);
        // Clockwise detent wraps the maximum to the minimum.
        step_pins(1'b1, 1'b0);
        step_pins(1'b0, 1'b0);
        step_pins(1'b0, 1'b1);
        step_pins(1'b1, 1'b1);
        // Counter-clockwise detent wraps it back.
        step_pins(1'b0, 1'b1);
        step_pins(1'b0, 1'b0);
        step_pins(1'b1, 1'b0);
        step_pins(1'b1, 1'b1);
        load_count(32'sh8000_0000);
        // Both low from idle, back off from running, abort from start.
        step_pins(1'b0, 1'b0);
        step_pins(1'b0, 1'b0);
        step_pins(1'b0, 1'b1);
        step_pins(1'b1, 1'b1);
        // Load inside a clockwise detent, then bounce between wait and running.
        step_pins(1'b1, 1'b0);
        load_count(-32'sd1);
        step_pins(1'b0, 1'b0);
        step_pins(1'b0, 1'b1);
        step_pins(1'b0, 1'b0);
        step_pins(1'b0, 1'b1);
        step_pins(1'b1, 1'b1);
        // Counter-clockwise detent with a bounce from wait back to running.
        step_pins(1'b0, 1'b1);
        step_pins(1'b0, 1'b0);
        step_pins(1'b1, 1'b0);
        step_pins(1'b0, 1'b0);
        step_pins(1'b1, 1'b0);
        step_pins(1'b1, 1'b1);
        settle_block();
    endtask

    // Sweep the modulus through its extremes with loads and detents at each setting.
    task automatic test_modulus_corners();
        logic [31:0] corners[6];
        corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'd7};
        foreach (corners[i])
        begin
            write_modulus(corners[i]);
            load_count(-32'sd1);
            load_count(32'sh7FFF_FFFF);
            repeat (6)
            begin
                if ($urandom_range(2) == 0)
                    load_count(pick_load_value());
                else
                    walk_detent(1'($urandom_range(1)));
            end
            settle_block();
        end
    endtask

    // Stall the result side for a long stretch while offering transactions
    // back to back, so the block fills and drops its input ready.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        hold_req = HOLD_CYCLES;
        repeat (4)
            walk_detent(1'($urandom_range(1)));
        idle_on = 1'b1;
        settle_block();
    endtask

    // Mostly well-formed detent walks, some pin noise and loads; change the
    // modulus every few hundred transactions, with one long quiet stretch.
    task automatic test_random_rotation();
        int roll;
        int last_write;
        last_write = items_sent;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent - last_write >= 300)
            begin
                settle_block();
                write_modulus(pick_modulus());
                last_write = items_sent;
            end
            idle_on = !(items_sent >= QUIET_START && items_sent < QUIET_START + QUIET_LEN);
            roll = $urandom_range(99);
            if (roll < 70)
                walk_detent(1'($urandom_range(1)));
            else if (roll < 85)
                send_item(OP_STEP, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
            else
                send_item(OP_LOAD, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          pick_load_value());
        end
        idle_on = 1'b1;
        settle_block();
    endtask

    // Long receiver hold-off, counted here so the test only asks for it.
    initial
    begin
        hold_on <= 1'b0;
        forever
        begin
            wait (hold_req != 0);
            hold_on <= 1'b1;
            repeat (hold_req) @(posedge clk);
            hold_on <= 1'b0;
            hold_req = 0;
        end
    end

    // Compare each result transaction with the oldest expectation, then pick
    // the next ready level: stall at random, or hold during the hold-off.
    always @(posedge clk)
    begin : result_monitor
        detent_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result total_steps %0d wrapped_steps %0d",
                         $time, out_ch.total_steps, out_ch.wrapped_steps);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.detent == DET_CW) cw_detents++;
                if (want.detent == DET_CCW) ccw_detents++;
                if (out_ch.total_steps !== want.total)
                begin
                    $display("%0t: total_steps expected %0d actual %0d",
                             $time, want.total, out_ch.total_steps);
                    mismatches++;
                end
                if (out_ch.wrapped_steps !== want.wrapped)
                begin
                    $display("%0t: wrapped_steps expected %0d actual %0d",
                             $time, want.wrapped, out_ch.wrapped_steps);
                    mismatches++;
                end
                if (out_ch.detent_event !== want.detent)
                begin
                    $display("%0t: detent_event expected %0d actual %0d",
                             $time, want.detent, out_ch.detent_event);
                    mismatches++;
                end
                if (out_ch.phase !== want.phase)
                begin
                    $display("%0t: phase expected %0d actual %0d",
                             $time, want.phase, out_ch.phase);
                    mismatches++;
                end
            end
        end
        out_ch.ready <= rst_n && !hold_on && !(idle_on && $urandom_range(99) < 13);
    end

    // Guard against a hung block.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("quadrature_encoder_decoder_tb: errors");
        $finish;
    end

    // Reset once, then run the tests in turn and report.
    initial
    begin
        phase_shadow   = PH_IDLE;
        count_shadow   = '0;
        modulus_shadow = MOD_RESET;
        mismatches     = 0;
        items_sent     = 0;
        results_seen   = 0;
        cw_detents     = 0;
        ccw_detents    = 0;
        modulus_writes = 0;
        idle_on        = 1'b1;
        hold_req       = 0;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_STEP;
        in_ch.pin_a      <= 1'b1;
        in_ch.pin_b      <= 1'b1;
        in_ch.load_value <= '0;
        cfg.valid        <= 1'b0;
        cfg.data         <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_detents();
        test_modulus_corners();
        test_output_backpressure();
        test_random_rotation();

        repeat (BLOCK_LATENCY) @(posedge clk);
        $display("covered %0d transactions and %0d results, %0d cw and %0d ccw detents",
                 items_sent, results_seen, cw_detents, ccw_detents);
        $display("with %0d modulus writes, wrap at both count extremes and a long output stall",
                 modulus_writes);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("quadrature_encoder_decoder_tb: clean");
        else
            $display("quadrature_encoder_decoder_tb: errors");
        $finish;
    end

endmodule
